### rtl/rgba_gamma_correction_top_defines.svh
// assertion macros for the rgba gamma correction block
// used by the rtl top module, which carries concurrent checks on aclk / aresetn
`ifndef RGBA_GAMMA_CORRECTION_TOP_DEFINES_SVH
`define RGBA_GAMMA_CORRECTION_TOP_DEFINES_SVH

// check that is held off during reset
`define RGC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// check that is also evaluated while reset is applied
`define RGC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### rtl/rgc_pkg.sv
// shared types, constants and the exp2 root table for rgba gamma correction
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rgc_pkg;

    localparam int LEVELS_DEFAULT = 256;
    localparam int ADDR_MAX_W     = 10;
    localparam logic [15:0] GAMMA_RESET = 16'd4096;

    typedef enum logic [3:0] {
        BLD_START,
        BLD_LOG_INIT,
        BLD_LOG_STEP,
        BLD_LOG_END,
        BLD_DIV,
        BLD_DIV_END,
        BLD_EXP,
        BLD_MUL,
        BLD_SCALE,
        BLD_WRITE,
        BLD_IDLE
    } bld_state_t;

    // table write port from the builder to the lookup memories
    typedef struct packed {
        logic                  en;
        logic [ADDR_MAX_W-1:0] addr;
        logic [7:0]            data;
    } tbl_wr_t;

    typedef logic [15:0][29:0] root_tab_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] t;
        res = '0;
        for (int b = 31; b >= 0; b--) begin
            t = res | (64'd1 << b);
            if (t * t <= v) begin
                res = t;
            end
        end
        return res;
    endfunction

    // root[j] = 2^(-2^-(j+1)) in q30
    function automatic root_tab_t build_roots();
        root_tab_t   tab;
        logic [63:0] c;
        c = isqrt64(64'd1 << 59);
        tab[0] = c[29:0];
        for (int j = 1; j < 16; j++) begin
            c = isqrt64(c << 30);
            tab[j] = c[29:0];
        end
        return tab;
    endfunction

    localparam root_tab_t EXP_ROOTS = build_roots();

endpackage

`default_nettype wire

### rtl/rgba_gamma_correction_top.sv
// an item is registered in stage one, in the table read and in the output register
// throughput: one item per cycle once the table is built; stalls hold every stage
// reset and every gamma write start a table rebuild (the log2 / divide / exp2
// sequencer), during which s_axis_tready is low
// reset: aresetn synchronous active low, gamma returns to 1.0
`timescale 1ns / 1ps
`default_nettype none

`include "rgba_gamma_correction_top_defines.svh"

module rgba_gamma_correction_top #(
    parameter int LEVELS = rgc_pkg::LEVELS_DEFAULT
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_wr_en,
    input  wire  [15:0] cfg_wr_data,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // red_in, green_in, blue_in, alpha_in
    input  wire         s_axis_tlast,   // frame_end_in
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // red_out, green_out, blue_out, alpha_out
    output logic        m_axis_tlast    // frame_end_out
);

    localparam int LW = $clog2(LEVELS);
    localparam int IW = (LW > 8) ? LW : 8;
    localparam logic [IW-1:0] TOP_EXT = IW'(LEVELS - 1);

    rgc_pkg::tbl_wr_t tbl_wr;
    logic             bld_ready;

    logic          v1_reg;
    logic [LW-1:0] idx1_reg [3];
    logic [7:0]    a1_reg;
    logic          l1_reg;
    logic          v2_reg;
    logic [7:0]    a2_reg;
    logic          l2_reg;
    logic [7:0]    rd2 [3];

    logic          adv_out, adv2, adv1, in_acc;
    logic [LW-1:0] idx_in [3];

    rgc_table_build #(.LEVELS(LEVELS)) u_build (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .wr          (tbl_wr),
        .ready       (bld_ready)
    );

    assign adv_out       = !m_axis_tvalid || m_axis_tready;
    assign adv2          = !v2_reg || adv_out;
    assign adv1          = !v1_reg || adv2;
    assign s_axis_tready = adv1 && bld_ready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // levels above the table top saturate
    always_comb begin
        logic [IW-1:0] lv;
        for (int c = 0; c < 3; c++) begin
            lv = IW'(s_axis_tdata[8*c +: 8]);
            idx_in[c] = (lv > TOP_EXT) ? TOP_EXT[LW-1:0] : lv[LW-1:0];
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_lut
        rgc_lut #(.LEVELS(LEVELS)) u_lut (
            .aclk    (aclk),
            .wr      (tbl_wr),
            .rd_en   (adv2),
            .rd_addr (idx1_reg[c]),
            .rd_data (rd2[c])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            m_axis_tvalid <= 1'b0;
        end else begin
            if (adv1) v1_reg <= in_acc;
            if (adv2) v2_reg <= v1_reg;
            if (adv_out) m_axis_tvalid <= v2_reg;
        end
        if (adv1) begin
            for (int c = 0; c < 3; c++) idx1_reg[c] <= idx_in[c];
            a1_reg <= s_axis_tdata[31:24];
            l1_reg <= s_axis_tlast;
        end
        if (adv2) begin
            a2_reg <= a1_reg;
            l2_reg <= l1_reg;
        end
        if (adv_out) begin
            m_axis_tdata <= {a2_reg, rd2[2], rd2[1], rd2[0]};
            m_axis_tlast <= l2_reg;
        end
    end

    `RGC_ASSERT(a_acc_to_stage1, (s_axis_tvalid && s_axis_tready) |=> v1_reg, "accepted item lost")
    `RGC_ASSERT(a_no_acc_building, !bld_ready |-> !(s_axis_tvalid && s_axis_tready), "item during rebuild")
    `RGC_ASSERT(a_stage2_kept, (v2_reg && m_axis_tvalid && !m_axis_tready) |=> v2_reg, "stage two dropped")
    `RGC_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !m_axis_tvalid, "output valid after reset")

endmodule

`default_nettype wire

### rtl/rgc_lut.sv
// one copy of the level lookup table: single write port, registered read
// depends on rgc_pkg for the write port struct
`timescale 1ns / 1ps
`default_nettype none

module rgc_lut #(
    parameter int LEVELS = rgc_pkg::LEVELS_DEFAULT
) (
    input  wire                        aclk,
    input  rgc_pkg::tbl_wr_t           wr,
    input  wire                        rd_en,
    input  wire [$clog2(LEVELS)-1:0]   rd_addr,
    output logic [7:0]                 rd_data
);

    localparam int LW = $clog2(LEVELS);

    logic [7:0] mem [LEVELS];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr[LW-1:0]] <= wr.data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/rgc_table_build.sv
// table builder: holds gamma, rebuilds the level table with a sequenced
// log2 / divide / exp2 unit; depends on rgc_pkg
`timescale 1ns / 1ps
`default_nettype none

module rgc_table_build #(
    parameter int LEVELS = rgc_pkg::LEVELS_DEFAULT
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               cfg_wr_en,
    input  wire [15:0]        cfg_wr_data,
    output rgc_pkg::tbl_wr_t  wr,
    output logic              ready
);

    localparam int LW = $clog2(LEVELS);
    localparam int PW = LW + 31;
    localparam logic [LW-1:0] TOP = LW'(LEVELS - 1);
    localparam logic [7:0] TOP_SAT = (LEVELS - 1 > 255) ? 8'd255 : 8'(LEVELS - 1);

    rgc_pkg::bld_state_t state_reg, state_next;

    logic [15:0]   gamma_reg, gamma_next;
    logic [LW-1:0] cur_reg, cur_next;
    logic          top_reg, top_next;
    logic [19:0]   ltop_reg, ltop_next;
    logic [3:0]    e_reg, e_next;
    logic [31:0]   m_reg, m_next;
    logic [15:0]   frac_reg, frac_next;
    logic [5:0]    step_reg, step_next;
    logic [15:0]   rem_reg, rem_next;
    logic [32:0]   quo_reg, quo_next;
    logic [3:0]    k_reg, k_next;
    logic [15:0]   f_reg, f_next;
    logic [30:0]   r_reg, r_next;
    logic [PW-1:0] prod_reg, prod_next;
    logic [7:0]    val_reg, val_next;

    logic [3:0]    enc;
    logic [63:0]   sq;
    logic [32:0]   sq_sh;
    logic [19:0]   lval;
    logic [19:0]   n_val;
    logic [16:0]   trial;
    logic          ge;
    logic [61:0]   rprod;
    logic [47:0]   rsum;
    logic [47:0]   rsh;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rgc_pkg::BLD_START:    state_next = rgc_pkg::BLD_LOG_INIT;
            rgc_pkg::BLD_LOG_INIT: state_next = rgc_pkg::BLD_LOG_STEP;
            rgc_pkg::BLD_LOG_STEP: begin
                if (step_reg == 6'd15) state_next = rgc_pkg::BLD_LOG_END;
            end
            rgc_pkg::BLD_LOG_END: begin
                if (top_reg) state_next = rgc_pkg::BLD_LOG_INIT;
                else if (gamma_reg == '0) state_next = rgc_pkg::BLD_WRITE;
                else state_next = rgc_pkg::BLD_DIV;
            end
            rgc_pkg::BLD_DIV: begin
                if (step_reg == 6'd32) state_next = rgc_pkg::BLD_DIV_END;
            end
            rgc_pkg::BLD_DIV_END: begin
                if (|quo_reg[32:20]) state_next = rgc_pkg::BLD_WRITE;
                else state_next = rgc_pkg::BLD_EXP;
            end
            rgc_pkg::BLD_EXP: begin
                if (step_reg == 6'd0) state_next = rgc_pkg::BLD_MUL;
            end
            rgc_pkg::BLD_MUL:   state_next = rgc_pkg::BLD_SCALE;
            rgc_pkg::BLD_SCALE: state_next = rgc_pkg::BLD_WRITE;
            rgc_pkg::BLD_WRITE: begin
                if (cur_reg == TOP) state_next = rgc_pkg::BLD_IDLE;
                else state_next = rgc_pkg::BLD_LOG_INIT;
            end
            rgc_pkg::BLD_IDLE: state_next = rgc_pkg::BLD_IDLE;
            default:           state_next = rgc_pkg::BLD_START;
        endcase
        if (cfg_wr_en) begin
            state_next = rgc_pkg::BLD_START;
        end
    end

    // outputs
    always_comb begin
        wr    = '0;
        ready = 1'b0;
        case (state_reg)
            rgc_pkg::BLD_START: begin
                wr.en   = 1'b1;
                wr.addr = '0;
                wr.data = '0;
            end
            rgc_pkg::BLD_WRITE: begin
                wr.en   = 1'b1;
                wr.addr = rgc_pkg::ADDR_MAX_W'(cur_reg);
                wr.data = val_reg;
            end
            rgc_pkg::BLD_IDLE: ready = 1'b1;
            default: ;
        endcase
    end

    // datapath
    always_comb begin
        gamma_next = cfg_wr_en ? cfg_wr_data : gamma_reg;
        cur_next   = cur_reg;
        top_next   = top_reg;
        ltop_next  = ltop_reg;
        e_next     = e_reg;
        m_next     = m_reg;
        frac_next  = frac_reg;
        step_next  = step_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        k_next     = k_reg;
        f_next     = f_reg;
        r_next     = r_reg;
        prod_next  = prod_reg;
        val_next   = val_reg;

        enc = '0;
        for (int b = 0; b < LW; b++) begin
            if (cur_reg[b]) enc = 4'(b);
        end
        sq    = 64'(m_reg) * 64'(m_reg);
        sq_sh = 33'(sq >> 31);
        lval  = {e_reg, frac_reg};
        n_val = (ltop_reg > lval) ? (ltop_reg - lval) : '0;
        trial = {rem_reg, quo_reg[32]};
        ge    = trial >= {1'b0, gamma_reg};
        rprod = 62'(r_reg) * 62'(rgc_pkg::EXP_ROOTS[~step_reg[3:0]]);
        rsum  = 48'(prod_reg) + (48'd1 << (6'd29 + 6'(k_reg)));
        rsh   = rsum >> (6'd30 + 6'(k_reg));

        case (state_reg)
            rgc_pkg::BLD_START: begin
                cur_next = TOP;
                top_next = 1'b1;
            end
            rgc_pkg::BLD_LOG_INIT: begin
                e_next    = enc;
                m_next    = 32'(cur_reg) << (5'd31 - {1'b0, enc});
                frac_next = '0;
                step_next = '0;
            end
            rgc_pkg::BLD_LOG_STEP: begin
                // square, then renormalize when the mantissa reaches 2.0
                m_next    = sq_sh[32] ? sq_sh[32:1] : sq_sh[31:0];
                frac_next = {frac_reg[14:0], sq_sh[32]};
                step_next = step_reg + 6'd1;
            end
            rgc_pkg::BLD_LOG_END: begin
                if (top_reg) begin
                    ltop_next = lval;
                    top_next  = 1'b0;
                    cur_next  = LW'(1);
                end else if (gamma_reg == '0) begin
                    val_next = (n_val == '0) ? TOP_SAT : 8'd0;
                end else begin
                    rem_next  = '0;
                    quo_next  = 33'({n_val, 12'd0}) + 33'(gamma_reg >> 1);
                    step_next = '0;
                end
            end
            rgc_pkg::BLD_DIV: begin
                rem_next  = ge ? 16'(trial - {1'b0, gamma_reg}) : trial[15:0];
                quo_next  = {quo_reg[31:0], ge};
                step_next = step_reg + 6'd1;
            end
            rgc_pkg::BLD_DIV_END: begin
                val_next  = '0;
                k_next    = quo_reg[19:16];
                f_next    = quo_reg[15:0];
                r_next    = 31'd1 << 30;
                step_next = 6'd15;
            end
            rgc_pkg::BLD_EXP: begin
                if (f_reg[step_reg[3:0]]) r_next = 31'(rprod >> 30);
                step_next = step_reg - 6'd1;
            end
            rgc_pkg::BLD_MUL: begin
                prod_next = PW'(TOP) * PW'(r_reg);
            end
            rgc_pkg::BLD_SCALE: begin
                val_next = (rsh > 48'd255) ? 8'd255 : rsh[7:0];
            end
            rgc_pkg::BLD_WRITE: begin
                cur_next = cur_reg + LW'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rgc_pkg::BLD_START;
            gamma_reg <= rgc_pkg::GAMMA_RESET;
        end else begin
            state_reg <= state_next;
            gamma_reg <= gamma_next;
        end
        cur_reg  <= cur_next;
        top_reg  <= top_next;
        ltop_reg <= ltop_next;
        e_reg    <= e_next;
        m_reg    <= m_next;
        frac_reg <= frac_next;
        step_reg <= step_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        k_reg    <= k_next;
        f_reg    <= f_next;
        r_reg    <= r_next;
        prod_reg <= prod_next;
        val_reg  <= val_next;
    end

endmodule

`default_nettype wire

### tb/sv/rgba_gamma_correction_top_tb.sv
// self-checking testbench for rgba_gamma_correction_top: drives pixel items
// under several gamma settings and idle patterns, predicts every corrected pixel
// depends on rtl/rgc_pkg.sv and rtl/rgba_gamma_correction_top.sv
`timescale 1ns / 1ps

class gamma_scoreboard;
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last;
    } pixel_t;

    bit [7:0]  level_map [256];
    bit [31:0] half_roots [16];
    bit [15:0] gamma_q12;
    pixel_t    pending_pixels [$];
    int        errors;
    int        checked;

    function bit [63:0] int_sqrt(bit [63:0] v);
        bit [63:0] acc;
        bit [63:0] t;
        acc = 0;
        for (int b = 31; b >= 0; b--) begin
            t = acc | (64'd1 << b);
            if (t * t <= v) begin
                acc = t;
            end
        end
        return acc;
    endfunction

    // log2 in q16 by repeated squaring of a q1.31 mantissa
    function bit [63:0] log2_fixed(bit [31:0] x);
        bit [31:0] e;
        bit [63:0] m;
        bit [63:0] frac;
        e = 0;
        frac = 0;
        for (int b = 0; b < 11; b++) begin
            if (x[b]) begin
                e = b;
            end
        end
        m = 64'(x) << (31 - e);
        for (int s = 0; s < 16; s++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= (64'd1 << 32)) begin
                frac = frac | 1;
                m = m >> 1;
            end
        end
        return (64'(e) << 16) + frac;
    endfunction

    function void rebuild_map();
        bit [63:0] ltop, li, n, q, k, r, val;
        bit [15:0] f;
        ltop = log2_fixed(255);
        level_map[0] = 0;
        for (int i = 1; i <= 255; i++) begin
            li = log2_fixed(i);
            n = (ltop > li) ? ltop - li : 0;
            if (gamma_q12 == 0) begin
                val = (n == 0) ? 255 : 0;
            end else begin
                q = (n * 4096 + (gamma_q12 >> 1)) / gamma_q12;
                k = q >> 16;
                if (k >= 16) begin
                    val = 0;
                end else begin
                    r = 64'd1 << 30;
                    f = q[15:0];
                    for (int t = 15; t >= 0; t--) begin
                        if (f[t]) begin
                            r = (r * half_roots[15 - t]) >> 30;
                        end
                    end
                    val = (255 * r + (64'd1 << (29 + k))) >> (30 + k);
                end
            end
            level_map[i] = (val > 255) ? 8'd255 : val[7:0];
        end
    endfunction

    function new();
        bit [63:0] c;
        c = int_sqrt(64'd1 << 59);
        half_roots[0] = c[31:0];
        for (int j = 1; j < 16; j++) begin
            c = int_sqrt(c << 30);
            half_roots[j] = c[31:0];
        end
        errors = 0;
        checked = 0;
        set_gamma(16'd4096);
    endfunction

    function void set_gamma(bit [15:0] g);
        gamma_q12 = g;
        rebuild_map();
    endfunction

    function int pending();
        return pending_pixels.size();
    endfunction

    function void note_pixel(logic [31:0] data, logic last);
        pixel_t p;
        p.red   = level_map[data[7:0]];
        p.green = level_map[data[15:8]];
        p.blue  = level_map[data[23:16]];
        p.alpha = data[31:24];
        p.last  = last;
        pending_pixels.push_back(p);
    endfunction

    function void check_pixel(logic [31:0] data, logic last);
        pixel_t e;
        if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected item data=%h last=%b", $time, data, last);
            errors++;
            return;
        end
        e = pending_pixels.pop_front();
        checked++;
        if (data[7:0] !== e.red) begin
            $display("%0t: red exp %0d got %0d", $time, e.red, data[7:0]);
            errors++;
        end
        if (data[15:8] !== e.green) begin
            $display("%0t: green exp %0d got %0d", $time, e.green, data[15:8]);
            errors++;
        end
        if (data[23:16] !== e.blue) begin
            $display("%0t: blue exp %0d got %0d", $time, e.blue, data[23:16]);
            errors++;
        end
        if (data[31:24] !== e.alpha) begin
            $display("%0t: alpha exp %0d got %0d", $time, e.alpha, data[31:24]);
            errors++;
        end
        if (last !== e.last) begin
            $display("%0t: last exp %b got %b", $time, e.last, last);
            errors++;
        end
    endfunction
endclass

module rgba_gamma_correction_top_tb;
    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;

    gamma_scoreboard pixel_sb;
    int send_idle_pct;
    int recv_stall_pct;
    int gamma_writes;

    rgba_gamma_correction_top DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("timeout at %0t", $time);
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                pixel_sb.note_pixel(s_axis_tdata, s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                pixel_sb.check_pixel(m_axis_tdata, m_axis_tlast);
            end
        end
    end

    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic send_pixel(input logic [31:0] data, input logic last);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tlast  <= last;
        do begin
            @(posedge aclk);
        end while (!s_axis_tready);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        // let the last accepted item be noted before the pending count is polled
        @(posedge aclk);
        while (pixel_sb.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_gamma(input logic [15:0] g);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= g;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        pixel_sb.set_gamma(g);
        gamma_writes++;
        // let the rebuild pull tready low
        repeat (3) @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'($urandom_range(1, 8));
            3: return 8'($urandom_range(247, 254));
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic random_pixels(input int count);
        logic [31:0] d;
        for (int i = 0; i < count; i++) begin
            d = {pick_level(), pick_level(), pick_level(), pick_level()};
            send_pixel(d, ($urandom_range(0, 15) == 0));
            if (i == count / 2 && $urandom_range(0, 1) == 0) begin
                drain();
            end
        end
    endtask

    logic [15:0] gamma_plan [8];

    initial begin
        pixel_sb       = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        gamma_writes   = 0;
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tlast   = 1'b0;
        m_axis_tready  = 1'b1;
        gamma_plan = '{16'd0, 16'd40960, 16'd65535, 16'd1, 16'd2048,
                       16'd8192, 16'($urandom_range(1, 40960)), 16'd4096};
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: level extremes, alpha extremes, frame end both ways
        send_pixel(32'h00000000, 1'b0);
        send_pixel(32'hFFFFFFFF, 1'b1);
        send_pixel(32'h00FF01FE, 1'b0);
        send_pixel(32'hFF01FE00, 1'b1);
        send_pixel(32'h55AA807F, 1'b0);
        send_pixel(32'hAA55017F, 1'b0);
        random_pixels(100);

        foreach (gamma_plan[p]) begin
            write_gamma(gamma_plan[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            send_pixel(32'hFF00FF00, 1'b0);
            send_pixel(32'h00FEFF01, 1'b1);
            random_pixels(90);
        end

        drain();
        $display("covered %0d pixels over %0d gamma writes including zero and full scale",
                 pixel_sb.checked, gamma_writes);
        $display("idle patterns: none, sender gaps, receiver stalls, both");
        if (pixel_sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
